>>> sv/prl_pkg.sv
// Shared widths, constants and types for the point reflection unit.
package prl_pkg;

   localparam int COORD_WIDTH = 32;
   // differences of two coordinates
   localparam int DIFF_W      = COORD_WIDTH + 1;
   // product of two differences
   localparam int PROD_W      = 2 * DIFF_W;
   // squared length and dot product
   localparam int DD_W        = PROD_W + 1;
   // 4 * |dot| * |d|
   localparam int NUM_W       = DD_W + DIFF_W + 2;
   // quotient bits kept (|4*dot*d/dd| <= 4*|v| < 2^(COORD_WIDTH+5))
   localparam int QUO_W       = COORD_WIDTH + 5;
   localparam int REM_W       = DD_W + 1;
   localparam int LO_W        = (DD_W + 1) / 2;
   localparam int HI_W        = DD_W - LO_W;
   // 2*a - p
   localparam int OFS_W       = COORD_WIDTH + 2;
   localparam int RES_W       = QUO_W + 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [RES_W-1:0] RES_MAX =
      {{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [RES_W-1:0] RES_MIN =
      {{(RES_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   // classified item handed from front to back
   typedef struct packed {
      logic signed [DIFF_W-1:0]      dx;
      logic signed [DIFF_W-1:0]      dy;
      logic signed [DIFF_W-1:0]      vx;
      logic signed [DIFF_W-1:0]      vy;
      logic signed [OFS_W-1:0]       base_x;
      logic signed [OFS_W-1:0]       base_y;
      logic signed [COORD_WIDTH-1:0] px;
      logic signed [COORD_WIDTH-1:0] py;
      logic                          degen;
   } prl_item_type;

   // values that ride along the back pipeline
   typedef struct packed {
      logic                          vld;
      logic                          degen;
      logic                          neg_x;
      logic                          neg_y;
      logic signed [OFS_W-1:0]       base_x;
      logic signed [OFS_W-1:0]       base_y;
      logic signed [COORD_WIDTH-1:0] px;
      logic signed [COORD_WIDTH-1:0] py;
   } prl_side_type;

endpackage

>>> sv/prl_front.sv
// Front stage: accepts items, forms differences and flags coinciding line points.
module prl_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0]   req_line_a_x,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0]   req_line_a_y,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0]   req_line_b_x,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0]   req_line_b_y,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0]   req_point_x,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0]   req_point_y,
   input  logic                                     q_full,
   output logic                                     item_vld,
   output prl_pkg::prl_item_type                    item
);

   localparam int CW = prl_pkg::COORD_WIDTH;

   logic                  vld_ff, vld_in;
   prl_pkg::prl_item_type item_ff, item_in;
   logic                  accept;

   assign req_full = vld_ff && q_full;
   assign accept   = req_push && !req_full;
   assign item_vld = vld_ff;
   assign item     = item_ff;

   always_comb begin
      item_in.dx = $signed({req_line_b_x[CW-1], req_line_b_x})
                 - $signed({req_line_a_x[CW-1], req_line_a_x});
      item_in.dy = $signed({req_line_b_y[CW-1], req_line_b_y})
                 - $signed({req_line_a_y[CW-1], req_line_a_y});
      item_in.vx = $signed({req_point_x[CW-1], req_point_x})
                 - $signed({req_line_a_x[CW-1], req_line_a_x});
      item_in.vy = $signed({req_point_y[CW-1], req_point_y})
                 - $signed({req_line_a_y[CW-1], req_line_a_y});
      item_in.base_x = $signed({req_line_a_x[CW-1], req_line_a_x, 1'b0})
                     - $signed({{2{req_point_x[CW-1]}}, req_point_x});
      item_in.base_y = $signed({req_line_a_y[CW-1], req_line_a_y, 1'b0})
                     - $signed({{2{req_point_y[CW-1]}}, req_point_y});
      item_in.px    = req_point_x;
      item_in.py    = req_point_y;
      item_in.degen = (req_line_a_x == req_line_b_x) && (req_line_a_y == req_line_b_y);
   end

   always_comb begin
      if (accept) begin
         vld_in = 1'b1;
      end else if (vld_ff && !q_full) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> sv/prl_queue.sv
// Short queue of classified items between front and back.
module prl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  prl_pkg::prl_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output prl_pkg::prl_item_type head
);

   localparam int PW = prl_pkg::QPTR_W;

   prl_pkg::prl_item_type mem_ff [prl_pkg::QUEUE_DEPTH];
   logic [PW-1:0]         wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]           cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full    = (cnt_ff == (PW+1)'(prl_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

>>> sv/prl_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
module prl_divider (
   input  logic                          clock,
   input  logic                          en,
   input  logic [prl_pkg::NUM_W-1:0]     num,
   input  logic [prl_pkg::DD_W-1:0]      den,
   output logic [prl_pkg::QUO_W-1:0]     quo
);

   localparam int QW = prl_pkg::QUO_W;
   localparam int RW = prl_pkg::REM_W;
   localparam int NW = prl_pkg::NUM_W;
   localparam int DW = prl_pkg::DD_W;

   logic [RW-1:0] rem_ff [QW];
   logic [RW-1:0] rem_in [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] low_in [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [QW-1:0] quo_in [QW];
   logic [DW-1:0] den_ff [QW];

   generate
      for (genvar i = 0; i < QW; i++) begin : g_stage
         logic [RW-1:0] rem_prev;
         logic [RW-1:0] shifted;
         logic [QW-1:0] low_prev;
         logic [QW-1:0] quo_prev;
         logic [DW-1:0] den_prev;
         logic          ge;

         if (i == 0) begin : g_first
            // upper bits start the remainder; they are below den
            assign rem_prev = RW'(num[NW-1:QW]);
            assign low_prev = num[QW-1:0];
            assign quo_prev = '0;
            assign den_prev = den;
         end else begin : g_next
            assign rem_prev = rem_ff[i-1];
            assign low_prev = low_ff[i-1];
            assign quo_prev = quo_ff[i-1];
            assign den_prev = den_ff[i-1];
         end

         always_comb begin
            shifted   = {rem_prev[RW-2:0], low_prev[QW-1]};
            ge        = (shifted >= RW'(den_prev));
            rem_in[i] = ge ? shifted - RW'(den_prev) : shifted;
            low_in[i] = {low_prev[QW-2:0], 1'b0};
            quo_in[i] = {quo_prev[QW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= rem_in[i];
               low_ff[i] <= low_in[i];
               quo_ff[i] <= quo_in[i];
               den_ff[i] <= den_prev;
            end
         end
      end
   endgenerate

   assign quo = quo_ff[QW-1];

endmodule

>>> sv/prl_back.sv
// Back pipeline: dot products, scaled correction, division, rounding, clamp.
module prl_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   item_vld,
   input  prl_pkg::prl_item_type                  item,
   output logic                                   item_pop,
   input  logic                                   rsp_pop,
   output logic                                   rsp_empty,
   output logic signed [prl_pkg::COORD_WIDTH-1:0] rsp_mirror_x,
   output logic signed [prl_pkg::COORD_WIDTH-1:0] rsp_mirror_y,
   output logic                                   rsp_degenerate,
   output logic                                   rsp_saturated
);

   localparam int CW = prl_pkg::COORD_WIDTH;
   localparam int DF = prl_pkg::DIFF_W;
   localparam int PW = prl_pkg::PROD_W;
   localparam int DW = prl_pkg::DD_W;
   localparam int NW = prl_pkg::NUM_W;
   localparam int QW = prl_pkg::QUO_W;
   localparam int LW = prl_pkg::LO_W;
   localparam int HW = prl_pkg::HI_W;
   localparam int OW = prl_pkg::OFS_W;
   localparam int RW = prl_pkg::RES_W;

   logic adv;

   // stage 1: products
   prl_pkg::prl_side_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   logic signed [PW-1:0]  dxx_ff, dyy_ff, vdx_ff, vdy_ff;
   logic [DF-1:0]         adx_ff, ady_ff, adx2_ff, ady2_ff, adx3_ff, ady3_ff;
   logic [DF-1:0]         adx_in, ady_in;
   // stage 2: sums
   logic [DW-1:0]         dd2_ff, dd3_ff, dd4_ff, dd5_ff;
   logic signed [DW-1:0]  dot_ff;
   // stage 3: magnitude of dot
   logic [DW-1:0]         dotm_ff;
   // stage 4: partial products
   logic [LW+DF-1:0]      plo_x_ff, plo_y_ff;
   logic [HW+DF-1:0]      phi_x_ff, phi_y_ff;
   // stage 5: numerators
   logic [NW-1:0]         num_x_ff, num_y_ff;

   prl_pkg::prl_side_type side_ff [QW];
   logic [QW-1:0]         quo_x, quo_y;

   prl_pkg::prl_side_type last;
   logic [QW-1:0]         rnd_x, rnd_y;
   logic signed [RW-1:0]  sum_x, sum_y;
   logic [CW-1:0]         mx_in, my_in;
   logic                  sx, sy;

   logic                  rsp_vld_ff;
   logic [CW-1:0]         mx_ff, my_ff;
   logic                  degen_ff, sat_ff;

   // whole pipeline moves unless a finished result is waiting and not popped
   assign adv      = !rsp_vld_ff || rsp_pop;
   assign item_pop = adv && item_vld;

   assign adx_in = item.dx[DF-1] ? DF'(-item.dx) : DF'(item.dx);
   assign ady_in = item.dy[DF-1] ? DF'(-item.dy) : DF'(item.dy);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
         s2_ff.vld <= 1'b0;
         s3_ff.vld <= 1'b0;
         s4_ff.vld <= 1'b0;
         s5_ff.vld <= 1'b0;
      end else if (adv) begin
         s1_ff.vld <= item_vld;
         s2_ff.vld <= s1_ff.vld;
         s3_ff.vld <= s2_ff.vld;
         s4_ff.vld <= s3_ff.vld;
         s5_ff.vld <= s4_ff.vld;
         // stage 1
         s1_ff.degen  <= item.degen;
         s1_ff.neg_x  <= item.dx[DF-1];
         s1_ff.neg_y  <= item.dy[DF-1];
         s1_ff.base_x <= item.base_x;
         s1_ff.base_y <= item.base_y;
         s1_ff.px     <= item.px;
         s1_ff.py     <= item.py;
         dxx_ff       <= $signed(item.dx) * $signed(item.dx);
         dyy_ff       <= $signed(item.dy) * $signed(item.dy);
         vdx_ff       <= $signed(item.vx) * $signed(item.dx);
         vdy_ff       <= $signed(item.vy) * $signed(item.dy);
         adx_ff       <= adx_in;
         ady_ff       <= ady_in;
         // stage 2
         {s2_ff.degen, s2_ff.neg_x, s2_ff.neg_y} <= {s1_ff.degen, s1_ff.neg_x, s1_ff.neg_y};
         {s2_ff.base_x, s2_ff.base_y, s2_ff.px, s2_ff.py} <=
            {s1_ff.base_x, s1_ff.base_y, s1_ff.px, s1_ff.py};
         dd2_ff  <= DW'({1'b0, dxx_ff}) + DW'({1'b0, dyy_ff});
         dot_ff  <= $signed({vdx_ff[PW-1], vdx_ff}) + $signed({vdy_ff[PW-1], vdy_ff});
         adx2_ff <= adx_ff;
         ady2_ff <= ady_ff;
         // stage 3: fold the dot sign into each offset sign
         s3_ff.degen <= s2_ff.degen;
         s3_ff.neg_x <= s2_ff.neg_x ^ dot_ff[DW-1];
         s3_ff.neg_y <= s2_ff.neg_y ^ dot_ff[DW-1];
         {s3_ff.base_x, s3_ff.base_y, s3_ff.px, s3_ff.py} <=
            {s2_ff.base_x, s2_ff.base_y, s2_ff.px, s2_ff.py};
         dotm_ff <= dot_ff[DW-1] ? DW'(-dot_ff) : DW'(dot_ff);
         dd3_ff  <= dd2_ff;
         adx3_ff <= adx2_ff;
         ady3_ff <= ady2_ff;
         // stage 4
         {s4_ff.degen, s4_ff.neg_x, s4_ff.neg_y} <= {s3_ff.degen, s3_ff.neg_x, s3_ff.neg_y};
         {s4_ff.base_x, s4_ff.base_y, s4_ff.px, s4_ff.py} <=
            {s3_ff.base_x, s3_ff.base_y, s3_ff.px, s3_ff.py};
         plo_x_ff <= dotm_ff[LW-1:0] * adx3_ff;
         plo_y_ff <= dotm_ff[LW-1:0] * ady3_ff;
         phi_x_ff <= dotm_ff[DW-1:LW] * adx3_ff;
         phi_y_ff <= dotm_ff[DW-1:LW] * ady3_ff;
         dd4_ff   <= dd3_ff;
         // stage 5: numerator times four
         {s5_ff.degen, s5_ff.neg_x, s5_ff.neg_y} <= {s4_ff.degen, s4_ff.neg_x, s4_ff.neg_y};
         {s5_ff.base_x, s5_ff.base_y, s5_ff.px, s5_ff.py} <=
            {s4_ff.base_x, s4_ff.base_y, s4_ff.px, s4_ff.py};
         num_x_ff <= {(NW-2)'(plo_x_ff) + {phi_x_ff, {LW{1'b0}}}, 2'b00};
         num_y_ff <= {(NW-2)'(plo_y_ff) + {phi_y_ff, {LW{1'b0}}}, 2'b00};
         dd5_ff   <= dd4_ff;
      end
   end

   prl_divider u_div_x (
      .clock (clock),
      .en    (adv),
      .num   (num_x_ff),
      .den   (dd5_ff),
      .quo   (quo_x)
   );

   prl_divider u_div_y (
      .clock (clock),
      .en    (adv),
      .num   (num_y_ff),
      .den   (dd5_ff),
      .quo   (quo_y)
   );

   // sideband delay matching the divider depth
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QW; i++) begin
            side_ff[i].vld <= 1'b0;
         end
      end else if (adv) begin
         side_ff[0] <= s5_ff;
         for (int i = 1; i < QW; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign last = side_ff[QW-1];

   // round half away from zero, apply sign, clamp; degenerate items keep the point
   always_comb begin
      rnd_x = QW'(({1'b0, quo_x} + (QW+1)'(1)) >> 1);
      rnd_y = QW'(({1'b0, quo_y} + (QW+1)'(1)) >> 1);
      sum_x = last.neg_x
            ? $signed({{(RW-OW){last.base_x[OW-1]}}, last.base_x}) - $signed(RW'(rnd_x))
            : $signed({{(RW-OW){last.base_x[OW-1]}}, last.base_x}) + $signed(RW'(rnd_x));
      sum_y = last.neg_y
            ? $signed({{(RW-OW){last.base_y[OW-1]}}, last.base_y}) - $signed(RW'(rnd_y))
            : $signed({{(RW-OW){last.base_y[OW-1]}}, last.base_y}) + $signed(RW'(rnd_y));
      sx = 1'b0;
      sy = 1'b0;
      if (sum_x > $signed(prl_pkg::RES_MAX)) begin
         mx_in = prl_pkg::RES_MAX[CW-1:0];
         sx    = 1'b1;
      end else if (sum_x < $signed(prl_pkg::RES_MIN)) begin
         mx_in = prl_pkg::RES_MIN[CW-1:0];
         sx    = 1'b1;
      end else begin
         mx_in = sum_x[CW-1:0];
      end
      if (sum_y > $signed(prl_pkg::RES_MAX)) begin
         my_in = prl_pkg::RES_MAX[CW-1:0];
         sy    = 1'b1;
      end else if (sum_y < $signed(prl_pkg::RES_MIN)) begin
         my_in = prl_pkg::RES_MIN[CW-1:0];
         sy    = 1'b1;
      end else begin
         my_in = sum_y[CW-1:0];
      end
      if (last.degen) begin
         mx_in = last.px;
         my_in = last.py;
         sx    = 1'b0;
         sy    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= last.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         degen_ff <= last.degen;
         sat_ff   <= sx || sy;
      end
   end

   assign rsp_empty      = !rsp_vld_ff;
   assign rsp_mirror_x   = mx_ff;
   assign rsp_mirror_y   = my_ff;
   assign rsp_degenerate = degen_ff;
   assign rsp_saturated  = sat_ff;

endmodule

>>> sv/point_reflect_across_line_unit.sv
// Top level of the point reflection unit: mirrors a point across a line.
// A pushed item passes the front register, the queue, the back stages, the divider and the result register.
// Throughput: one item per cycle while results are popped; set by the 37-stage pipelined divider pair.
// The front register and a 4-entry queue keep taking items while the back stalls.
// Reset (synchronous, active high) empties the front, queue and back pipeline.
module point_reflect_across_line_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // input queue side
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0] req_line_a_x,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0] req_line_a_y,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0] req_line_b_x,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0] req_line_b_y,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [prl_pkg::COORD_WIDTH-1:0] req_point_y,
   // result queue side
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [prl_pkg::COORD_WIDTH-1:0] rsp_mirror_x,
   output logic signed [prl_pkg::COORD_WIDTH-1:0] rsp_mirror_y,
   output logic                                   rsp_degenerate,
   output logic                                   rsp_saturated
);

   // front -> queue
   logic                  f_vld;
   prl_pkg::prl_item_type f_item;
   logic                  q_full;
   // queue -> back
   logic                  q_empty;
   logic                  q_pop;
   prl_pkg::prl_item_type q_head;

   // Front: registers the transfer, computes d = b - a, v = p - a, 2a - p
   // and the coinciding-points flag.
   prl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_line_a_x (req_line_a_x),
      .req_line_a_y (req_line_a_y),
      .req_line_b_x (req_line_b_x),
      .req_line_b_y (req_line_b_y),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .q_full       (q_full),
      .item_vld     (f_vld),
      .item         (f_item)
   );

   // Decoupling queue: lets the front keep going while the back is held.
   prl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_vld),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Back: R = (2a - p) +/- round(2*|v.d|*|d| / (d.d)), clamped; the whole
   // pipeline advances together and holds while a result waits for pop.
   prl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_vld       (!q_empty),
      .item           (q_head),
      .item_pop       (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_mirror_x   (rsp_mirror_x),
      .rsp_mirror_y   (rsp_mirror_y),
      .rsp_degenerate (rsp_degenerate),
      .rsp_saturated  (rsp_saturated)
   );

   // coinciding line points pass the point through, never clamped
   a_degen_no_sat: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_degenerate) |-> !rsp_saturated)
      else $error("degenerate result flagged as saturated");

   // a clamped result sits on a range bound in at least one coordinate
   a_sat_on_bound: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_saturated) |->
         (rsp_mirror_x[prl_pkg::COORD_WIDTH-2:0] == '1 &&
          !rsp_mirror_x[prl_pkg::COORD_WIDTH-1]) ||
         (rsp_mirror_x[prl_pkg::COORD_WIDTH-2:0] == '0 &&
          rsp_mirror_x[prl_pkg::COORD_WIDTH-1]) ||
         (rsp_mirror_y[prl_pkg::COORD_WIDTH-2:0] == '1 &&
          !rsp_mirror_y[prl_pkg::COORD_WIDTH-1]) ||
         (rsp_mirror_y[prl_pkg::COORD_WIDTH-2:0] == '0 &&
          rsp_mirror_y[prl_pkg::COORD_WIDTH-1]))
      else $error("saturated result not on a bound");

   // reset leaves no result and no held input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("state left after reset");

endmodule
